FILE: hdl/binary_max_heap_queue_top_assert.svh
// assertion macros for the heap queue checker
// no dependencies; included by the checker file only
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define BMHQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BMHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bmhq_pkg.sv
// shared types and constants of the binary max-heap queue
// no dependencies
package bmhq_pkg;

   localparam int STATUS_BITS   = 2;
   localparam int CAP_BITS      = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   // register index taken from paddr bit 2
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic OP_INSERT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_DN_FIRST,
      ST_DN_RD,
      ST_PLACE,
      ST_FINISH
   } bmhq_state_type;

endpackage

FILE: hdl/bmhq_req_if.sv
// request channel of the heap queue: valid, ready and operation payload
// depends on nothing but its parameters
interface bmhq_req_if #(
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 32
);
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [PRIORITY_BITS-1:0] priority_req;
   logic [PAYLOAD_BITS-1:0]  payload;

   modport source (output valid, output operation, output priority_req, output payload,
                   input ready);
   modport sink (input valid, input operation, input priority_req, input payload,
                 output ready);
endinterface

FILE: hdl/bmhq_rsp_if.sv
// response channel of the heap queue: valid, ready and result payload
// depends on bmhq_pkg for the status width
interface bmhq_rsp_if
   import bmhq_pkg::*;
#(
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 32,
   parameter int COUNT_BITS    = 7
);
   logic                     valid;
   logic                     ready;
   logic [STATUS_BITS-1:0]   status;
   logic [PRIORITY_BITS-1:0] out_priority;
   logic [PAYLOAD_BITS-1:0]  out_payload;
   logic [COUNT_BITS-1:0]    entry_count;

   modport source (output valid, output status, output out_priority, output out_payload,
                   output entry_count, input ready);
   modport sink (input valid, input status, input out_priority, input out_payload,
                 input entry_count, output ready);
endinterface

FILE: hdl/binary_max_heap_queue_top.sv
// channel   dir  handshake      payload
// req_chan  in   valid/ready    operation, priority_req, payload
// rsp_chan  out  valid/ready    status, out_priority, out_payload, entry_count
// csr_*     in   apb, pready=1  capacity at byte address 0
//
// one operation at a time; insert and remove each walk one heap level per cycle
// through the single write port and the registered read data of the heap memory
// synchronous reset clears control state and count and sets capacity to CAP_RESET; heap contents need no clearing
// a held response does not block acceptance, only the hand-off of the next result
//
// binary max-heap priority queue built around one heap memory
// depends on bmhq_pkg, bmhq_req_if and bmhq_rsp_if
module binary_max_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int DEPTH         = 64,
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   bmhq_req_if.sink                 req_chan,
   bmhq_rsp_if.source               rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int EW   = PRIORITY_BITS + PAYLOAD_BITS;
   localparam int CHW  = IW + 2;
   localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] p);
      logic [IW-1:0] pm;
      pm = p - IW'(1);
      parent_of = pm >> 1;
   endfunction

   bmhq_state_type state_ff, state_in;

   logic [CW-1:0]       count_ff, count_in;
   logic [CAP_BITS-1:0] cap_ff, cap_in;
   logic [EW-1:0]       cur_ff, cur_in;
   logic [IW-1:0]       pos_ff, pos_in;

   logic [STATUS_BITS-1:0]   res_status_ff, res_status_in;
   logic [PRIORITY_BITS-1:0] res_prio_ff, res_prio_in;
   logic [PAYLOAD_BITS-1:0]  res_pay_ff, res_pay_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [PAYLOAD_BITS-1:0]  rsp_pay_ff, rsp_pay_in;
   logic [CW-1:0]            rsp_count_ff, rsp_count_in;

   // heap memory, one write and two reads per cycle, registered read data
   logic [EW-1:0] heap_mem [DEPTH];
   logic [EW-1:0] rd_a_ff, rd_b_ff;
   logic [IW-1:0] rd_a_addr, rd_b_addr, mem_waddr;
   logic [EW-1:0] mem_wdata;
   logic          mem_we;

   // decode shared by the next-state and output blocks
   logic                     req_xfer, slot_free, has_room, csr_wr;
   logic [PRIORITY_BITS-1:0] cur_prio, a_prio, b_prio, win_prio;
   logic [CHW-1:0]           l_w, r_w, n_w, bl_w, br_w;
   logic                     l_ok, r_ok, pick_l, pick_r, moved, dn_more;
   logic [IW-1:0]            best, pos_par;
   logic [EW-1:0]            best_entry;
   logic [CW-1:0]            count_m1;
   logic                     up_swap;

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign has_room  = (count_ff < DEPTH_C) && (CMPW'(count_ff) < CMPW'(cap_ff));
   assign count_m1  = count_ff - CW'(1);

   assign cur_prio = cur_ff[EW-1 -: PRIORITY_BITS];
   assign a_prio   = rd_a_ff[EW-1 -: PRIORITY_BITS];
   assign b_prio   = rd_b_ff[EW-1 -: PRIORITY_BITS];

   assign l_w      = CHW'({pos_ff, 1'b1});
   assign r_w      = l_w + CHW'(1);
   assign n_w      = CHW'(count_ff);
   assign l_ok     = l_w < n_w;
   assign r_ok     = r_w < n_w;
   // left child wins on strictly greater, right child must beat that winner
   assign pick_l   = l_ok && (a_prio > cur_prio);
   assign win_prio = pick_l ? a_prio : cur_prio;
   assign pick_r   = r_ok && (b_prio > win_prio);
   assign moved    = pick_l || pick_r;
   assign best     = pick_r ? r_w[IW-1:0] : l_w[IW-1:0];
   assign best_entry = pick_r ? rd_b_ff : rd_a_ff;
   assign bl_w     = CHW'({best, 1'b1});
   assign br_w     = bl_w + CHW'(1);
   assign dn_more  = bl_w < n_w;

   assign pos_par  = parent_of(pos_ff);
   assign up_swap  = cur_prio > a_prio;

   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.operation == OP_INSERT) begin
                  if (has_room && count_ff != '0) state_in = ST_UP_RD;
                  else                             state_in = ST_FINISH;
               end else begin
                  if (count_ff != '0) state_in = ST_DN_FIRST;
                  else                state_in = ST_FINISH;
               end
            end
         end
         ST_UP_RD: begin
            if (!up_swap)            state_in = ST_FINISH;
            else if (pos_par == '0)  state_in = ST_PLACE;
         end
         ST_DN_FIRST: begin
            if (CHW'(1) < n_w) state_in = ST_DN_RD;
            else               state_in = ST_FINISH;
         end
         ST_DN_RD: begin
            if (!moved)       state_in = ST_FINISH;
            else if (!dn_more) state_in = ST_PLACE;
         end
         ST_PLACE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in      = count_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_prio_in   = res_prio_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_count_in  = rsp_count_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_prio_in = '0;
               res_pay_in  = '0;
               if (req_chan.operation == OP_INSERT) begin
                  if (has_room) begin
                     res_status_in = STATUS_OK;
                     count_in      = count_ff + CW'(1);
                     cur_in        = {req_chan.priority_req, req_chan.payload};
                     pos_in        = count_ff[IW-1:0];
                     rd_a_addr     = parent_of(count_ff[IW-1:0]);
                     if (count_ff == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = {req_chan.priority_req, req_chan.payload};
                     end
                  end else begin
                     res_status_in = STATUS_FULL;
                  end
               end else begin
                  if (count_ff != '0) begin
                     res_status_in = STATUS_OK;
                     count_in      = count_m1;
                     rd_a_addr     = '0;
                     rd_b_addr     = count_m1[IW-1:0];
                  end else begin
                     res_status_in = STATUS_EMPTY;
                  end
               end
            end
         end
         ST_UP_RD: begin
            mem_we = 1'b1;
            if (up_swap) begin
               // parent moves down into the hole
               mem_wdata = rd_a_ff;
               pos_in    = pos_par;
               rd_a_addr = parent_of(pos_par);
            end
         end
         ST_DN_FIRST: begin
            res_prio_in = rd_a_ff[EW-1 -: PRIORITY_BITS];
            res_pay_in  = rd_a_ff[PAYLOAD_BITS-1:0];
            cur_in      = rd_b_ff;
            pos_in      = '0;
            rd_a_addr   = IW'(1);
            rd_b_addr   = CHW'(2) < CHW'(DEPTH) ? IW'(2) : '0;
            if (!(CHW'(1) < n_w)) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = rd_b_ff;
            end
         end
         ST_DN_RD: begin
            mem_we = 1'b1;
            if (moved) begin
               // winning child moves up into the hole
               mem_wdata = best_entry;
               pos_in    = best;
               rd_a_addr = bl_w[IW-1:0];
               rd_b_addr = br_w[IW-1:0];
            end
         end
         ST_PLACE: begin
            mem_we = 1'b1;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_prio_in   = res_prio_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign cap_in = (csr_wr && csr_paddr[2] == REG_CAPACITY) ? csr_pwdata[CAP_BITS-1:0]
                                                            : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_prio_ff   <= res_prio_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_priority = rsp_prio_ff;
   assign rsp_chan.out_payload  = rsp_pay_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? CSR_DATA_BITS'(cap_ff) : '0;

endmodule

FILE: hdl/bmhq_checker.sv
// port-level checks of the heap queue and the bind that attaches them
// depends on bmhq_pkg and binary_max_heap_queue_top_assert.svh
`include "binary_max_heap_queue_top_assert.svh"

module bmhq_checker
   import bmhq_pkg::*;
#(
   parameter int DEPTH         = 64,
   parameter int PRIORITY_BITS = 16,
   parameter int PAYLOAD_BITS  = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_BITS-1:0]   rsp_status,
   input logic [PRIORITY_BITS-1:0] rsp_priority,
   input logic [PAYLOAD_BITS-1:0]  rsp_payload,
   input logic [$clog2(DEPTH+1)-1:0] rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   // a held response keeps its contents
   `BMHQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_priority) && $stable(rsp_payload)
      && $stable(rsp_count), "response changed while stalled")

   // one operation in flight: no transfer right after a transfer
   `BMHQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready,
      "request accepted while an operation is in progress")

   // a failed remove leaves an empty queue and carries no entry
   `BMHQ_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY,
      rsp_count == '0 && rsp_priority == '0 && rsp_payload == '0,
      "empty response with data or nonzero count")

   // count never exceeds the heap depth
   `BMHQ_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_count <= CW'(DEPTH),
      "entry count above depth")

endmodule

bind binary_max_heap_queue_top bmhq_checker #(
   .DEPTH(DEPTH),
   .PRIORITY_BITS(PRIORITY_BITS),
   .PAYLOAD_BITS(PAYLOAD_BITS)
) u_bmhq_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_priority(rsp_chan.out_priority),
   .rsp_payload(rsp_chan.out_payload),
   .rsp_count(rsp_chan.entry_count)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for the binary max-heap queue: directed then random insert/remove traffic
// depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and binary_max_heap_queue_top

localparam int HEAP_SLOTS = 64;
localparam int PRIO_W     = 16;
localparam int PAY_W      = 32;
localparam int COUNT_W    = 7;

typedef struct packed {
   logic [PRIO_W-1:0] prio;
   logic [PAY_W-1:0]  pay;
} heap_slot_t;

typedef struct packed {
   logic [bmhq_pkg::STATUS_BITS-1:0] status;
   logic [PRIO_W-1:0]                prio;
   logic [PAY_W-1:0]                 pay;
   logic [COUNT_W-1:0]               count;
} queue_result_t;

// shadow heap plus the results it owes the bench, oldest first
class heap_queue_tracker;
   heap_slot_t         slots[HEAP_SLOTS];
   int unsigned        held;
   logic [COUNT_W-1:0] capacity;
   queue_result_t      pending_results[$];
   int                 errors;

   function new();
      held     = 0;
      capacity = bmhq_pkg::CAP_RESET;
      errors   = 0;
   endfunction

   function void set_capacity(logic [COUNT_W-1:0] value);
      capacity = value;
   endfunction

   function void swap_slots(int unsigned a, int unsigned b);
      heap_slot_t tmp;
      tmp      = slots[a];
      slots[a] = slots[b];
      slots[b] = tmp;
   endfunction

   function void note_request(logic op, logic [PRIO_W-1:0] prio, logic [PAY_W-1:0] pay);
      queue_result_t res;
      int unsigned   limit;
      int unsigned   pos;
      int unsigned   up;
      int unsigned   left;
      int unsigned   right;
      int unsigned   best;
      res   = '0;
      limit = (capacity > HEAP_SLOTS) ? HEAP_SLOTS : capacity;
      if (op == bmhq_pkg::OP_INSERT) begin
         if (held < limit) begin
            slots[held].prio = prio;
            slots[held].pay  = pay;
            pos = held;
            held++;
            // climb while strictly larger than the parent
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (slots[pos].prio <= slots[up].prio) break;
               swap_slots(pos, up);
               pos = up;
            end
         end else begin
            res.status = bmhq_pkg::STATUS_FULL;
         end
      end else if (held == 0) begin
         res.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
         res.prio = slots[0].prio;
         res.pay  = slots[0].pay;
         held--;
         slots[0] = slots[held];
         pos = 0;
         // left wins only if strictly larger, right only if larger than that winner
         while (1) begin
            left  = 2 * pos + 1;
            right = left + 1;
            best  = pos;
            if (left < held && slots[left].prio > slots[best].prio) best = left;
            if (right < held && slots[right].prio > slots[best].prio) best = right;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
         end
      end
      res.count = COUNT_W'(held);
      pending_results.push_back(res);
   endfunction

   function void compare_field(string label, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want_v, got_v);
      end
   endfunction

   function void check_result(queue_result_t got);
      queue_result_t want;
      if (pending_results.size() == 0) begin
         errors++;
         $display("%0t: result with nothing outstanding, expected none actual status %0d count %0d",
                  $time, got.status, got.count);
         return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_priority", 32'(want.prio), 32'(got.prio));
      compare_field("out_payload", want.pay, got.pay);
      compare_field("entry_count", 32'(want.count), 32'(got.count));
   endfunction
endclass

module tb_top;
   import bmhq_pkg::*;

   localparam logic                     OP_REMOVE      = ~OP_INSERT;
   localparam logic [CSR_ADDR_BITS-1:0] CAPACITY_ADDR  = {REG_CAPACITY, 2'b00};
   localparam int                       WATCHDOG_LIMIT = 2000;
   localparam int                       PHASES         = 12;
   localparam int                       PHASE_ITEMS    = 88;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   bit            idle_on;
   int            stall_cycles;
   queue_result_t seen;

   heap_queue_tracker tracker = new();

   bmhq_req_if #(.PRIORITY_BITS(PRIO_W), .PAYLOAD_BITS(PAY_W)) req_chan ();
   bmhq_rsp_if #(.PRIORITY_BITS(PRIO_W), .PAYLOAD_BITS(PAY_W), .COUNT_BITS(COUNT_W)) rsp_chan ();

   binary_max_heap_queue_top #(
      .DEPTH(HEAP_SLOTS),
      .PRIORITY_BITS(PRIO_W),
      .PAYLOAD_BITS(PAY_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            tracker.note_request(req_chan.operation, req_chan.priority_req, req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.status = rsp_chan.status;
            seen.prio   = rsp_chan.out_priority;
            seen.pay    = rsp_chan.out_payload;
            seen.count  = rsp_chan.entry_count;
            tracker.check_result(seen);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // result side back-pressure in short bursts
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_item(input logic op, input logic [PRIO_W-1:0] prio,
                            input logic [PAY_W-1:0] pay);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.priority_req <= prio;
      req_chan.payload      <= pay;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold off new requests until every outstanding result has been taken
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
   endtask

   task automatic write_capacity(input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_capacity(value[COUNT_W-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   int phase_cap[PHASES]   = '{127, 64, 5, 0, 1, 64, 100, -1, 2, -1, 127, 64};
   int phase_ins_pct[PHASES] = '{90, 55, 25, 50, 50, 85, 50, 15, 50, 60, 90, 20};

   initial begin
      logic [CSR_DATA_BITS-1:0] cfg_value;
      logic [PRIO_W-1:0]        prio;
      int                       cap;
      reset                 = 1'b1;
      idle_on               = 1'b0;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_INSERT;
      req_chan.priority_req = '0;
      req_chan.payload      = '0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // remove on empty, extremes, equal priorities, then drain past empty
      send_item(OP_REMOVE, 16'h0000, 32'h0000_0000);
      send_item(OP_INSERT, 16'h0000, 32'h0000_0000);
      send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 16'h8000, 32'hA5A5_A5A5);
      send_item(OP_INSERT, 16'h7FFF, 32'h5A5A_5A5A);
      send_item(OP_INSERT, 16'h0001, 32'h0000_0001);
      send_item(OP_INSERT, 16'h8000, 32'h8000_0000);
      send_item(OP_INSERT, 16'h8000, 32'h7FFF_FFFF);
      repeat (8) send_item(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);

      // capacity of one, then zero
      drain_results();
      write_capacity(32'd1);
      idle_on = 1'b1;
      send_item(OP_INSERT, 16'h1234, 32'hDEAD_BEEF);
      send_item(OP_INSERT, 16'hFFFF, 32'h0000_0002);
      send_item(OP_REMOVE, 16'h0000, 32'h0000_0000);
      send_item(OP_REMOVE, 16'h0000, 32'h0000_0000);
      drain_results();
      write_capacity(32'd0);
      send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_REMOVE, 16'h0000, 32'h0000_0000);

      // count carries over between phases, so lower capacities can start above the limit
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         cap = (phase_cap[p] < 0) ? $urandom_range(0, 127) : phase_cap[p];
         cfg_value = 32'(cap);
         // upper data bits are not part of the register
         if (p == 6) begin
            cfg_value        = $urandom;
            cfg_value[COUNT_W-1:0] = COUNT_W'(cap);
         end
         write_capacity(cfg_value);
         idle_on = !(p == 1 || p == 6 || p >= PHASES - 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 3))
               0:       prio = PRIO_W'($urandom_range(0, 7));
               1:       prio = $urandom_range(0, 1) ? '1 : '0;
               default: prio = PRIO_W'($urandom_range(0, 65535));
            endcase
            send_item(($urandom_range(0, 99) < phase_ins_pct[p]) ? OP_INSERT : OP_REMOVE,
                      prio, PAY_W'($urandom));
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
